FILE: rtl/core/ebphr_pkg.sv
// Shared types and constants for the ECG biquad filter with beat detection.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ebphr_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned COEF_W     = 18;
  localparam int unsigned DELAY_W    = 32;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned PERIOD_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [TICK_W-1:0] BEAT_MIN_TICKS = 32'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_N0     = 3'd0,
    REG_COEF_N1     = 3'd1,
    REG_COEF_N2     = 3'd2,
    REG_COEF_D1     = 3'd3,
    REG_COEF_D2     = 3'd4,
    REG_FILTER_GAIN = 3'd5,
    REG_PERIOD_MS   = 3'd6,
    REG_PEAK_LEVEL  = 3'd7
  } cfg_reg_e;

  localparam logic signed [COEF_W-1:0] RST_COEF_UNITY = 18'sd16384;
  localparam logic signed [COEF_W-1:0] RST_COEF_ZERO  = 18'sd0;
  localparam logic [PERIOD_W-1:0]      RST_PERIOD_MS  = 8'd4;
  localparam logic [OUT_W-1:0]         RST_PEAK_LEVEL = 16'd800;

  typedef struct packed {
    logic signed [COEF_W-1:0] n0;
    logic signed [COEF_W-1:0] n1;
    logic signed [COEF_W-1:0] n2;
    logic signed [COEF_W-1:0] d1;
    logic signed [COEF_W-1:0] d2;
    logic signed [COEF_W-1:0] gain;
    logic [PERIOD_W-1:0]      period;
    logic [OUT_W-1:0]         level;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_D1     = 3'd0,
    MUL_D2     = 3'd1,
    MUL_N0     = 3'd2,
    MUL_N1     = 3'd3,
    MUL_N2     = 3'd4,
    MUL_GAIN   = 3'd5,
    MUL_PERIOD = 3'd6
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD   = 3'd0,
    ACC_LOAD_X = 3'd1,
    ACC_LOAD_P = 3'd2,
    ACC_ADD    = 3'd3,
    ACC_SUB    = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     w_load;
    logic     numr_load;
    logic     filt_load;
    logic     commit;
  } dp_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/ebphr_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on ebphr_pkg for the field widths.
`default_nettype none

interface ebphr_in_if import ebphr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic [TICK_W-1:0]   time_ticks;

  modport source (output valid, output sample, output time_ticks, input ready);
  modport sink   (input valid, input sample, input time_ticks, output ready);
endinterface

interface ebphr_out_if import ebphr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] filtered;
  logic             peak_flag;
  logic             beat;
  logic [OUT_W-1:0] interval_ms;

  modport source (output valid, output filtered, output peak_flag, output beat,
                  output interval_ms, input ready);
  modport sink   (input valid, input filtered, input peak_flag, input beat,
                  input interval_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ebphr_cfg.sv
// Configuration register file: coefficients, gain, tick period and peak level.
// Depends on ebphr_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module ebphr_cfg import ebphr_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COEF_N0:     cfg_d.n0     = $signed(cfg_data_i[COEF_W-1:0]);
        REG_COEF_N1:     cfg_d.n1     = $signed(cfg_data_i[COEF_W-1:0]);
        REG_COEF_N2:     cfg_d.n2     = $signed(cfg_data_i[COEF_W-1:0]);
        REG_COEF_D1:     cfg_d.d1     = $signed(cfg_data_i[COEF_W-1:0]);
        REG_COEF_D2:     cfg_d.d2     = $signed(cfg_data_i[COEF_W-1:0]);
        REG_FILTER_GAIN: cfg_d.gain   = $signed(cfg_data_i[COEF_W-1:0]);
        REG_PERIOD_MS:   cfg_d.period = cfg_data_i[PERIOD_W-1:0];
        REG_PEAK_LEVEL:  cfg_d.level  = cfg_data_i[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.n0     <= RST_COEF_UNITY;
      cfg_q.n1     <= RST_COEF_ZERO;
      cfg_q.n2     <= RST_COEF_ZERO;
      cfg_q.d1     <= RST_COEF_ZERO;
      cfg_q.d2     <= RST_COEF_ZERO;
      cfg_q.gain   <= RST_COEF_UNITY;
      cfg_q.period <= RST_PERIOD_MS;
      cfg_q.level  <= RST_PEAK_LEVEL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/ebphr_ctrl.sv
// Sequencer for one sample: steps the shared multiplier and accumulator of the
// datapath and owns the input ready and output valid. Depends on ebphr_pkg.
`default_nettype none

module ebphr_ctrl import ebphr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  output dp_cmd_t   cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_FB1   = 14'b00000000000010,
    S_FB2   = 14'b00000000000100,
    S_FB3   = 14'b00000000001000,
    S_WSAT  = 14'b00000000010000,
    S_NUM0  = 14'b00000000100000,
    S_NUM1  = 14'b00000001000000,
    S_NUM2  = 14'b00000010000000,
    S_NUM3  = 14'b00000100000000,
    S_NRND  = 14'b00001000000000,
    S_GAIN  = 14'b00010000000000,
    S_CLAMP = 14'b00100000000000,
    S_INTV  = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  dp_cmd_t cmd;

  always_comb begin
    state_d    = state_q;
    cmd        = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = S_FB1;
        end
      end
      // feedback sum: x*2^2F - d1*delay_one - d2*delay_two
      S_FB1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D1;
        cmd.acc_op  = ACC_LOAD_X;
        state_d     = S_FB2;
      end
      S_FB2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D2;
        cmd.acc_op  = ACC_SUB;
        state_d     = S_FB3;
      end
      S_FB3: begin
        cmd.acc_op = ACC_SUB;
        state_d    = S_WSAT;
      end
      S_WSAT: begin
        cmd.w_load = 1'b1;
        state_d    = S_NUM0;
      end
      // numerator sum: n0*w + n1*delay_one + n2*delay_two
      S_NUM0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_N0;
        state_d     = S_NUM1;
      end
      S_NUM1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_N1;
        cmd.acc_op  = ACC_LOAD_P;
        state_d     = S_NUM2;
      end
      S_NUM2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_N2;
        cmd.acc_op  = ACC_ADD;
        state_d     = S_NUM3;
      end
      S_NUM3: begin
        cmd.acc_op = ACC_ADD;
        state_d    = S_NRND;
      end
      S_NRND: begin
        cmd.numr_load = 1'b1;
        state_d       = S_GAIN;
      end
      S_GAIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN;
        state_d     = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.filt_load = 1'b1;
        state_d       = S_INTV;
      end
      S_INTV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PERIOD;
        state_d     = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd.commit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

`default_nettype wire

FILE: rtl/core/ebphr_dp.sv
// Datapath: shared signed multiplier, accumulator, rounding and saturation,
// filter delays and beat detection state. Depends on ebphr_pkg.
`default_nettype none

module ebphr_dp import ebphr_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire dp_cmd_t             cmd_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire logic [TICK_W-1:0]   time_ticks_i,
  output logic [OUT_W-1:0]         filtered_o,
  output logic                     peak_flag_o,
  output logic                     beat_o,
  output logic [OUT_W-1:0]         interval_ms_o
);

  localparam int unsigned F      = COEF_FRAC_BITS;
  localparam int unsigned XSH_W  = SAMPLE_W + 2 * F + 1;
  localparam int unsigned CD_W   = COEF_W + DELAY_W;
  localparam int unsigned ACC_W  = ((XSH_W > CD_W) ? XSH_W : CD_W) + 2;
  localparam int unsigned RND_W  = ACC_W + 1;
  localparam int unsigned NR_W   = RND_W - F;
  localparam int unsigned PR_W   = COEF_W + NR_W;
  localparam int unsigned YX_W   = PR_W + OUT_W + 2;

  localparam logic signed [RND_W-1:0]   RND_HALF = RND_W'(1) << (F - 1);
  localparam logic signed [DELAY_W-1:0] W_MAX    = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic signed [DELAY_W-1:0] W_MIN    = {1'b1, {(DELAY_W-1){1'b0}}};

  // per-item work registers
  logic [SAMPLE_W-1:0]       x_q;
  logic [TICK_W-1:0]         now_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic signed [PR_W-1:0]    prod_q, prod_d;
  logic signed [DELAY_W-1:0] w_q;
  logic signed [NR_W-1:0]    numr_q;
  logic [OUT_W-1:0]          filt_q, filt_d;

  // filter and detector state
  logic signed [DELAY_W-1:0] delay_one_q, delay_two_q;
  logic [OUT_W-1:0]          prev_q;
  logic                      in_peak_q;
  logic [TICK_W-1:0]         last_beat_q;
  logic [OUT_W-1:0]          interval_q;

  // result registers
  logic [OUT_W-1:0] res_filt_q, res_interval_q;
  logic             res_flag_q, res_beat_q;

  logic signed [COEF_W-1:0] mul_a;
  logic signed [NR_W-1:0]   mul_b;
  logic [TICK_W-1:0]        elapsed;
  logic signed [ACC_W-1:0]  acc_x, prod_ext;
  logic signed [RND_W-1:0]  rnd_sum, rnd_val;
  logic [RND_W-DELAY_W:0]   rnd_hi;
  logic signed [DELAY_W-1:0] w_sat;
  logic signed [YX_W-1:0]   y_ext;
  logic [OUT_W-1:0]         ms_sat;
  logic                     below, falling, flag, beat;

  assign elapsed = now_q - last_beat_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_D1: begin
        mul_a = cfg_i.d1;
        mul_b = NR_W'(delay_one_q);
      end
      MUL_D2: begin
        mul_a = cfg_i.d2;
        mul_b = NR_W'(delay_two_q);
      end
      MUL_N0: begin
        mul_a = cfg_i.n0;
        mul_b = NR_W'(w_q);
      end
      MUL_N1: begin
        mul_a = cfg_i.n1;
        mul_b = NR_W'(delay_one_q);
      end
      MUL_N2: begin
        mul_a = cfg_i.n2;
        mul_b = NR_W'(delay_two_q);
      end
      MUL_GAIN: begin
        mul_a = cfg_i.gain;
        mul_b = numr_q;
      end
      MUL_PERIOD: begin
        mul_a = $signed(COEF_W'(cfg_i.period));
        mul_b = $signed(NR_W'(elapsed));
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // accumulator
  assign acc_x    = $signed(ACC_W'(x_q) << (2 * F));
  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    case (cmd_i.acc_op)
      ACC_LOAD_X: acc_d = acc_x;
      ACC_LOAD_P: acc_d = prod_ext;
      ACC_ADD:    acc_d = acc_q + prod_ext;
      ACC_SUB:    acc_d = acc_q - prod_ext;
      default:    acc_d = acc_q;
    endcase
  end

  // round to nearest, ties up, then drop F fraction bits
  assign rnd_sum = RND_W'(acc_q) + RND_HALF;
  assign rnd_val = rnd_sum >>> F;
  assign rnd_hi  = rnd_val[RND_W-1:DELAY_W-1];

  always_comb begin
    if (&rnd_hi || ~|rnd_hi) begin
      w_sat = rnd_val[DELAY_W-1:0];
    end else if (rnd_val[RND_W-1]) begin
      w_sat = W_MIN;
    end else begin
      w_sat = W_MAX;
    end
  end

  // floor after the gain product, clamp to the unsigned output range
  assign y_ext = YX_W'(prod_q) >>> (2 * F);

  always_comb begin
    if (y_ext[YX_W-1]) begin
      filt_d = '0;
    end else if (|y_ext[YX_W-2:OUT_W]) begin
      filt_d = '1;
    end else begin
      filt_d = y_ext[OUT_W-1:0];
    end
  end

  // prod_q holds elapsed * period here, never negative
  assign ms_sat  = (|prod_q[PR_W-1:OUT_W]) ? '1 : prod_q[OUT_W-1:0];
  assign below   = (filt_q < cfg_i.level);
  assign falling = (filt_q < prev_q);
  assign flag    = below && falling;
  assign beat    = flag && !in_peak_q && (elapsed > BEAT_MIN_TICKS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q   <= sample_i;
      now_q <= time_ticks_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
    if (cmd_i.w_load) begin
      w_q <= w_sat;
    end
    if (cmd_i.numr_load) begin
      numr_q <= rnd_val[NR_W-1:0];
    end
    if (cmd_i.filt_load) begin
      filt_q <= filt_d;
    end
    if (cmd_i.commit) begin
      res_filt_q     <= filt_q;
      res_flag_q     <= flag;
      res_beat_q     <= beat;
      res_interval_q <= beat ? ms_sat : interval_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_one_q <= '0;
      delay_two_q <= '0;
      prev_q      <= '0;
      in_peak_q   <= 1'b0;
      last_beat_q <= '0;
      interval_q  <= '0;
    end else if (cmd_i.commit) begin
      delay_two_q <= delay_one_q;
      delay_one_q <= w_q;
      prev_q      <= filt_q;
      if (below) begin
        in_peak_q <= falling;
      end
      if (beat) begin
        last_beat_q <= now_q;
        interval_q  <= ms_sat;
      end
    end
  end

  assign filtered_o    = res_filt_q;
  assign peak_flag_o   = res_flag_q;
  assign beat_o        = res_beat_q;
  assign interval_ms_o = res_interval_q;

endmodule

`default_nettype wire

FILE: rtl/core/ecg_biquad_peak_heart_rate.sv
// Top level of the ECG biquad filter with peak and heart beat detection.
// Depends on ebphr_pkg, ebphr_if, ebphr_cfg, ebphr_ctrl and ebphr_dp.
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ------------------------------------------
//  in_ch     in   valid / ready      sample[11:0], time_ticks[31:0]
//  out_ch    out  valid / ready      filtered[15:0], peak_flag, beat,
//                                    interval_ms[15:0]
//  cfg       in   cfg_we_i (no ack)  cfg_idx_i[2:0], cfg_data_i[17:0]
//
// An item occupies the block for one accept step and 13 sequencer steps, set by
// the single shared signed multiplier (18-bit coefficient operand) that forms
// seven products in turn (two feedback, three numerator, gain, beat interval).
// The result lands in an output register when the last step commits it; the
// block returns to accepting a new item while that result waits to be taken.
// A stalled output holds the sequencer in its last step, before any state
// update. Reset is asynchronous, active low, and restores the register defaults.
`default_nettype none

module ecg_biquad_peak_heart_rate import ebphr_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  ebphr_in_if.sink                   in_ch,
  ebphr_out_if.source                out_ch
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  logic    in_ready;
  logic    out_valid;

  // register file
  ebphr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // sequencer: owns both handshakes
  ebphr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  // arithmetic, filter state and result registers
  ebphr_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sample_i      (in_ch.sample),
    .time_ticks_i  (in_ch.time_ticks),
    .filtered_o    (out_ch.filtered),
    .peak_flag_o   (out_ch.peak_flag),
    .beat_o        (out_ch.beat),
    .interval_ms_o (out_ch.interval_ms)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

`ifndef SYNTHESIS
  localparam int unsigned RESULT_LAT = 14;

  // the sequencer is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accepted item");

  // a beat is only recorded on a falling sample below the level
  a_beat_needs_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.beat) |-> out_ch.peak_flag)
    else $error("beat reported without peak flag");

  // a fresh result on an empty output traces back to an accepted item
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready, RESULT_LAT))
    else $error("result appeared without a matching accepted item");
`endif

endmodule

`default_nettype wire

FILE: test/ebphr_tb_pkg.sv
// Scoreboard for the ECG biquad filter with beat detection: predicts each result
// from the accepted samples and checks what the block returns.
// Depends on ebphr_pkg for the register codes, widths and reset values.
package ebphr_tb_pkg;
  import ebphr_pkg::*;

  localparam int unsigned FRAC_BITS = 14;

  typedef struct packed {
    logic [OUT_W-1:0] filtered;
    logic             peak_flag;
    logic             beat;
    logic [OUT_W-1:0] interval_ms;
  } heart_result_t;

  class beat_scoreboard;
    cfg_t               regs;
    int                 delay_one_q;
    int                 delay_two_q;
    logic [OUT_W-1:0]   last_filtered;
    logic [OUT_W-1:0]   interval_held;
    logic [TICK_W-1:0]  last_beat_tick;
    bit                 falling_run;
    heart_result_t      pending[$];
    int                 samples_in;
    int                 results_checked;
    int                 mismatches;
    int                 beats;
    int                 flags;
    int                 clamped;
    int                 saturated;
    int                 reg_writes;

    function new();
      regs = '{n0: RST_COEF_UNITY, n1: RST_COEF_ZERO, n2: RST_COEF_ZERO,
               d1: RST_COEF_ZERO, d2: RST_COEF_ZERO, gain: RST_COEF_UNITY,
               period: RST_PERIOD_MS, level: RST_PEAK_LEVEL};
      delay_one_q    = 0;
      delay_two_q    = 0;
      last_filtered  = '0;
      interval_held  = '0;
      last_beat_tick = '0;
      falling_run    = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_COEF_N0:     regs.n0 = data;
        REG_COEF_N1:     regs.n1 = data;
        REG_COEF_N2:     regs.n2 = data;
        REG_COEF_D1:     regs.d1 = data;
        REG_COEF_D2:     regs.d2 = data;
        REG_FILTER_GAIN: regs.gain = data;
        REG_PERIOD_MS:   regs.period = data[PERIOD_W-1:0];
        REG_PEAK_LEVEL:  regs.level = data[OUT_W-1:0];
        default: ;
      endcase
    endfunction

    // Drop F fraction bits, rounding half up.
    static function longint round_frac(longint v);
      return (v + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function int sat_delay(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) begin
        saturated++;
        return 32'sh7FFF_FFFF;
      end
      if (v < -longint'(32'sh7FFF_FFFF) - 1) begin
        saturated++;
        return 32'sh8000_0000;
      end
      return int'(v);
    endfunction

    function heart_result_t filter_and_detect(logic [SAMPLE_W-1:0] s, logic [TICK_W-1:0] t);
      longint            acc;
      longint            num;
      longint            y;
      longint            ms;
      int                w;
      logic [TICK_W-1:0] elapsed;
      heart_result_t     r;
      acc = (longint'(s) <<< (2 * FRAC_BITS))
          - longint'($signed(regs.d1)) * longint'(delay_one_q)
          - longint'($signed(regs.d2)) * longint'(delay_two_q);
      w = sat_delay(round_frac(acc));
      num = round_frac(longint'($signed(regs.n0)) * longint'(w)
                     + longint'($signed(regs.n1)) * longint'(delay_one_q)
                     + longint'($signed(regs.n2)) * longint'(delay_two_q));
      y = (num * longint'($signed(regs.gain))) >>> (2 * FRAC_BITS);
      delay_two_q = delay_one_q;
      delay_one_q = w;
      if (y < 0) begin
        y = 0;
        clamped++;
      end else if (y > 65535) begin
        y = 65535;
        clamped++;
      end
      r.filtered  = y[OUT_W-1:0];
      r.peak_flag = 1'b0;
      r.beat      = 1'b0;
      // at or above the level nothing changes, the falling run included
      if (r.filtered < regs.level) begin
        if (r.filtered < last_filtered) begin
          r.peak_flag = 1'b1;
          if (!falling_run) begin
            elapsed = t - last_beat_tick;
            if (elapsed > BEAT_MIN_TICKS) begin
              ms = longint'(elapsed) * longint'(regs.period);
              interval_held  = (ms > 65535) ? '1 : ms[OUT_W-1:0];
              last_beat_tick = t;
              r.beat = 1'b1;
            end
          end
          falling_run = 1'b1;
        end else begin
          falling_run = 1'b0;
        end
      end
      last_filtered = r.filtered;
      r.interval_ms = interval_held;
      return r;
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s, logic [TICK_W-1:0] t);
      samples_in++;
      pending.push_back(filter_and_detect(s, t));
    endfunction

    function void check_result(heart_result_t got);
      heart_result_t want;
      if (pending.size() == 0) begin
        $error("result with no sample pending: filtered %0d", got.filtered);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      results_checked++;
      beats += want.beat;
      flags += want.peak_flag;
      if (got.filtered !== want.filtered) begin
        $error("filtered: expected %0d, got %0d", want.filtered, got.filtered);
        mismatches++;
      end
      if (got.peak_flag !== want.peak_flag) begin
        $error("peak_flag: expected %0d, got %0d", want.peak_flag, got.peak_flag);
        mismatches++;
      end
      if (got.beat !== want.beat) begin
        $error("beat: expected %0d, got %0d", want.beat, got.beat);
        mismatches++;
      end
      if (got.interval_ms !== want.interval_ms) begin
        $error("interval_ms: expected %0d, got %0d", want.interval_ms, got.interval_ms);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: test/tb_top.sv
// Top-level testbench for ecg_biquad_peak_heart_rate: drives samples and register
// writes, stalls the result side and checks every result through the scoreboard.
// Depends on ebphr_pkg, the channel interfaces and ebphr_tb_pkg.
module tb_top;
  import ebphr_pkg::*;
  import ebphr_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES   = 400_000;
  localparam int ITEMS_PER_MODE = 36;
  localparam int HOLD_CYCLES    = 300;
  localparam int PRESSURE_ITEMS = 12;
  localparam int END_CYCLES     = 40;
  localparam int NUM_DIRECTED   = 24;

  // idle modes: none, sender idle, receiver stalling, both
  localparam int SEND_IDLE[4]  = '{0, 66, 0, 33};
  localparam int RECV_STALL[4] = '{0, 0, 66, 33};

  // Directed samples on the reset setup (filter passes the sample through,
  // level 800, 4 ms per tick). Walks: above level, first falling sample too
  // soon after the last beat, flat sample clearing the run, level keeping the
  // run, a real beat, elapsed exactly at and just over the minimum, tick wrap,
  // interval saturation and both extremes of sample and tick.
  localparam logic [SAMPLE_W-1:0] DIR_SAMPLE[NUM_DIRECTED] = '{
    12'd4095, 12'd0,   12'd0,   12'd900, 12'd700, 12'd600, 12'd900, 12'd500,
    12'd600,  12'd500, 12'd800, 12'd799, 12'd799, 12'd798, 12'd798, 12'd797,
    12'd900,  12'd100, 12'd200, 12'd150, 12'd160, 12'd140, 12'd4095, 12'd0};
  localparam logic [TICK_W-1:0] DIR_TICK[NUM_DIRECTED] = '{
    32'd0,   32'd10,  32'd20,  32'd30,  32'd100, 32'd200, 32'd210, 32'd300,
    32'd310, 32'd351, 32'd360, 32'd361, 32'd362, 32'd401, 32'd402, 32'd402,
    32'hFFFF_FFF0, 32'hFFFF_FFF0, 32'hFFFF_FFF1, 32'hFFFF_FFF8, 32'hFFFF_FFF9,
    32'h0000_0030, 32'hFFFF_FFFF, 32'h0000_0000};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ebphr_in_if  in_ch ();
  ebphr_out_if out_ch ();

  beat_scoreboard sb;

  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                hold_left = 0;
  bit                hold_go = 1'b0;
  bit                hold_done = 1'b0;
  int                cycle_count = 0;
  int                phases_run = 0;
  int                wave_level = 0;
  bit                wave_rising = 1'b1;
  logic [TICK_W-1:0] tick_now = '0;

  ecg_biquad_peak_heart_rate #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #2ns clk_i = 1'b1;
    #2ns clk_i = 1'b0;
  end

  // Timeout guard: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: stall at the current rate, or hold off entirely while a
  // long hold is counting down so the block backs up into its input.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: every register write, accepted sample and accepted result goes
  // to the scoreboard, sampled at the same edge the block sees.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) begin
        sb.write_reg(cfg_reg_e'(cfg_idx), cfg_data);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_sample(in_ch.sample, in_ch.time_ticks);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{filtered: out_ch.filtered, peak_flag: out_ch.peak_flag,
                          beat: out_ch.beat, interval_ms: out_ch.interval_ms});
      end
    end
  end

  // Offer one item; idle first at the current rate, then hold it until taken.
  // Call and return at a rising edge.
  task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic [TICK_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= s;
    in_ch.time_ticks <= t;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every predicted result has come back; step one
  // edge first so the monitor has noted the last accepted item.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic cfg_t make_cfg(int n0, int n1, int n2, int d1, int d2, int gain,
                                    int period, int level);
    cfg_t c;
    c.n0     = n0[COEF_W-1:0];
    c.n1     = n1[COEF_W-1:0];
    c.n2     = n2[COEF_W-1:0];
    c.d1     = d1[COEF_W-1:0];
    c.d2     = d2[COEF_W-1:0];
    c.gain   = gain[COEF_W-1:0];
    c.period = period[PERIOD_W-1:0];
    c.level  = level[OUT_W-1:0];
    return c;
  endfunction

  // Write all eight registers back to back; the block must be idle.
  task automatic load_config(input cfg_t c);
    cfg_reg_e              r;
    logic [CFG_DATA_W-1:0] d;
    r = r.first();
    repeat (r.num()) begin
      case (r)
        REG_COEF_N0:     d = c.n0;
        REG_COEF_N1:     d = c.n1;
        REG_COEF_N2:     d = c.n2;
        REG_COEF_D1:     d = c.d1;
        REG_COEF_D2:     d = c.d2;
        REG_FILTER_GAIN: d = c.gain;
        REG_PERIOD_MS:   d = CFG_DATA_W'(c.period);
        REG_PEAK_LEVEL:  d = CFG_DATA_W'(c.level);
        default:         d = '0;
      endcase
      cfg_we   <= 1'b1;
      cfg_idx  <= r;
      cfg_data <= d;
      @(posedge clk_i);
      r = r.next();
    end
    cfg_we <= 1'b0;
    phases_run++;
  endtask

  // Heartbeat-like train: a sawtooth between lo and hi with random slopes and
  // tick steps, so falling runs cross the level and beats get recorded.
  // About one item in eight is noise with a random sample and random tick.
  task automatic run_beat_train(input int count, input int lo, input int hi);
    int                  step;
    logic [SAMPLE_W-1:0] s;
    logic [TICK_W-1:0]   t;
    repeat (count) begin
      if ($urandom_range(0, 99) < 12) begin
        s = SAMPLE_W'($urandom_range(0, 4095));
        t = $urandom();
        tick_now = t;
      end else begin
        tick_now = tick_now + $urandom_range(1, 40);
        if ($urandom_range(0, 9) != 0) begin
          if (wave_rising) begin
            wave_level = wave_level + $urandom_range(0, 600);
            if (wave_level >= hi) begin
              wave_level  = hi;
              wave_rising = 1'b0;
            end
          end else begin
            step = $urandom_range(0, 300);
            wave_level = (wave_level > lo + step) ? wave_level - step : lo;
            if (wave_level == lo) wave_rising = 1'b1;
          end
        end
        s = wave_level[SAMPLE_W-1:0];
        t = tick_now;
      end
      send_item(s, t);
    end
  endtask

  // One chunk of the train under each idle mode.
  task automatic run_idle_modes(input int lo, input int hi);
    for (int m = 0; m < 4; m++) begin
      send_idle_pct = SEND_IDLE[m];
      stall_pct     = RECV_STALL[m];
      run_beat_train(ITEMS_PER_MODE, lo, hi);
    end
  endtask

  initial begin
    cfg_t phase_cfg[8];
    sb = new();
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.time_ticks = '0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_COEF_N0;
    cfg_data         = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset register values, no idling
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(DIR_SAMPLE[i], DIR_TICK[i]);
    end
    drain();

    // long hold on the result side while the sender keeps offering items
    tick_now = $urandom();
    hold_go  = 1'b1;
    run_beat_train(PRESSURE_ITEMS, 0, 2000);

    // pass-through, smoothing low-pass, all-max, all-min with zero period,
    // runaway feedback, scaled difference, two random sets, the last at half gain
    phase_cfg[0] = make_cfg(16384, 0, 0, 0, 0, 16384, 4, 800);
    phase_cfg[1] = make_cfg(4096, 4096, 4096, -8192, 4096, 16384, 1, 3000);
    phase_cfg[2] = make_cfg(131071, 131071, 131071, 131071, 131071, 131071, 255, 65535);
    phase_cfg[3] = make_cfg(-131072, -131072, -131072, -131072, -131072, -131072, 0, 0);
    phase_cfg[4] = make_cfg(16384, 0, 0, -131072, 131071, 16384, 8, 40000);
    phase_cfg[5] = make_cfg(16384, -16384, 0, 0, 0, 131071, 255, 2000);
    phase_cfg[6] = make_cfg($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom_range(1, 255), $urandom_range(0, 65535));
    phase_cfg[7] = make_cfg(16384 + $urandom_range(0, 8192), $urandom_range(0, 16384) - 8192,
                            $urandom_range(0, 16384) - 8192, $urandom_range(0, 8192) - 4096,
                            $urandom_range(0, 8192), 8192, 255, 1500);

    foreach (phase_cfg[p]) begin
      drain();
      load_config(phase_cfg[p]);
      wave_level  = 0;
      wave_rising = 1'b1;
      run_idle_modes(0, (p == 0) ? 3000 : 4095);
    end
    drain();

    // let any stray result surface before the verdict
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (END_CYCLES) @(posedge clk_i);

    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.mismatches++;
    end
    $display("Ran %0d register settings: %0d samples in, %0d results checked, %0d mismatches",
             phases_run + 1, sb.samples_in, sb.results_checked, sb.mismatches);
    $display("Saw %0d beats, %0d peak flags, %0d clamped outputs, %0d saturated delays",
             sb.beats, sb.flags, sb.clamped, sb.saturated);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
